// ===== design/gsba_pkg.sv =====
// Package with the item types, constants and helpers of the Gaussian sample bin averager.
package gsba_pkg;

  // Input item: two uniform draws.
  typedef struct packed {
    logic [13:0] uniform_a;
    logic [13:0] uniform_b;
  } in_item_t;

  // Result item: bin mean and bin number.
  typedef struct packed {
    logic signed [15:0] bin_mean;
    logic [15:0]        bin_number;
  } out_item_t;

  // Configuration write as it travels to the back end.
  typedef struct packed {
    logic        we;
    logic        index;
    logic [10:0] wdata;
  } cfg_wr_t;

  localparam logic CFG_SKIP_COUNT = 1'b0;
  localparam logic CFG_BIN_SIZE   = 1'b1;

  localparam logic [7:0]  SKIP_COUNT_RESET = 8'd1;
  localparam logic [10:0] BIN_SIZE_RESET   = 11'd1000;

  localparam logic [13:0] UNIF_MAX = 14'd9999;
  localparam logic [11:0] QUAD_1   = 12'd2500;
  localparam logic [12:0] QUAD_2   = 13'd5000;
  localparam logic [12:0] QUAD_3   = 13'd7500;
  localparam logic [13:0] QUAD_4   = 14'd10000;

  localparam logic [30:0] TWO_LN2_Q30    = 31'd1488522236;
  localparam logic [19:0] STEP_ANGLE_Q30 = 20'd674652;
  localparam logic [30:0] Q30_ONE        = 31'h4000_0000;

  localparam int HORNER_TERMS = 5;
  localparam int DIV_W        = 32;
  localparam int DIVISOR_W    = 11;

  // Reciprocals of the cosine series divisors, floor(2^s / k) + 1 with s = 32 + ceil(log2 k).
  // Multiplying a 32-bit dividend and shifting right by s gives the exact truncated quotient.
  localparam logic [32:0] RECIP_90 = 33'(((64'd1 << 39) / 64'd90) + 64'd1);
  localparam logic [32:0] RECIP_56 = 33'(((64'd1 << 38) / 64'd56) + 64'd1);
  localparam logic [32:0] RECIP_30 = 33'(((64'd1 << 37) / 64'd30) + 64'd1);
  localparam logic [32:0] RECIP_12 = 33'(((64'd1 << 36) / 64'd12) + 64'd1);
  localparam logic [32:0] RECIP_2  = 33'(((64'd1 << 33) / 64'd2) + 64'd1);

  // Elaboration-time log2 in Q16, same squaring method as the hardware unit.
  function automatic logic [19:0] log2_q16_f(input logic [13:0] x);
    logic [3:0]  e;
    logic [15:0] frac;
    logic [63:0] m;
    e    = 4'd0;
    frac = 16'd0;
    for (int i = 0; i < 13; i++) begin
      if ((x >> (e + 4'd1)) != 14'd0) e = e + 4'd1;
    end
    m = 64'(x) << (6'd30 - 6'(e));
    for (int i = 0; i < 16; i++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        m    = m >> 1;
        frac = frac | 16'd1;
      end
    end
    return {e, frac};
  endfunction

  localparam logic [19:0] LOG2_10000_Q16 = log2_q16_f(14'd10000);

  // Reciprocal of the cosine series divisor, innermost term first.
  function automatic logic [32:0] horner_recip(input logic [2:0] idx);
    logic [32:0] r;
    case (idx)
      3'd0:    r = RECIP_90;
      3'd1:    r = RECIP_56;
      3'd2:    r = RECIP_30;
      3'd3:    r = RECIP_12;
      default: r = RECIP_2;
    endcase
    return r;
  endfunction

  // Right shift that goes with each reciprocal.
  function automatic logic [5:0] horner_shift(input logic [2:0] idx);
    logic [5:0] s;
    case (idx)
      3'd0:    s = 6'd39;
      3'd1:    s = 6'd38;
      3'd2:    s = 6'd37;
      3'd3:    s = 6'd36;
      default: s = 6'd33;
    endcase
    return s;
  endfunction

endpackage

// ===== design/gsba_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module gsba_div import gsba_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_W-1:0]     dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 done,
  output logic [DIV_W-1:0]     quotient
);

  logic [DIV_W-1:0]         quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]     rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]     dvs_r;
  logic [$clog2(DIV_W)-1:0] cnt_r;
  logic                     busy_r, done_r;
  logic [DIVISOR_W:0]       trial;

  // One shift-and-subtract step.
  always_comb begin
    trial = {rem_r, quo_r[DIV_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = DIVISOR_W'(trial - {1'b0, dvs_r});
      quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DIVISOR_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
    end
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == $clog2(DIV_W)'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== design/gsba_front.sv =====
// Front end: accepts an item and forms one Gaussian sample in Q3.12.
module gsba_front import gsba_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               push,
  output logic signed [15:0] push_data,
  input  logic               full
);

  typedef enum logic [12:0] {
    F_IDLE = 13'b0000000000001,
    F_LOG  = 13'b0000000000010,
    F_DIFF = 13'b0000000000100,
    F_LQ   = 13'b0000000001000,
    F_SQI  = 13'b0000000010000,
    F_SQRT = 13'b0000000100000,
    F_CX   = 13'b0000001000000,
    F_CY   = 13'b0000010000000,
    F_HMUL = 13'b0000100000000,
    F_HDIV = 13'b0001000000000,
    F_HSUB = 13'b0010000000000,
    F_MAG  = 13'b0100000000000,
    F_PUSH = 13'b1000000000000
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic [13:0]        n1, n2;
  logic [3:0]         e_in;
  logic [3:0]         e_r;
  logic [15:0]        frac_r;
  logic [30:0]        m_r;
  logic [3:0]         it_r;
  logic [11:0]        a_r, a_in;
  logic               neg_r, neg_in;
  logic [19:0]        d_r;
  logic [20:0]        diff;
  logic [50:0]        lq_prod_r;
  logic [20:0]        lq;
  logic [36:0]        v_r, bit_r;
  logic [37:0]        res_r, res_bit;
  logic [31:0]        x_r, y_r;
  logic [30:0]        t_r;
  logic [2:0]         k_r;
  logic [61:0]        sq, xsq, yt;
  logic [31:0]        sq_hi;
  logic [49:0]        rc;
  logic [16:0]        mag;
  logic signed [15:0] z_r;
  logic [31:0]        q_r, quot_r;
  logic [64:0]        hprod;

  // Input clamping and the quadrant of the cosine draw.
  always_comb begin
    n1 = in_data.uniform_a;
    n2 = in_data.uniform_b;
    if (n1 == 14'd0) n1 = 14'd1;
    if (n1 > UNIF_MAX) n1 = UNIF_MAX;
    if (n2 > UNIF_MAX) n2 = UNIF_MAX;
    e_in = 4'd0;
    for (int i = 1; i < 14; i++) begin
      if (n1[i]) e_in = 4'(i);
    end
    if (n2 <= 14'(QUAD_1)) begin
      a_in = n2[11:0];
      neg_in = 1'b0;
    end else if (n2 <= 14'(QUAD_2)) begin
      a_in = 12'(14'(QUAD_2) - n2);
      neg_in = 1'b1;
    end else if (n2 <= 14'(QUAD_3)) begin
      a_in = 12'(n2 - 14'(QUAD_2));
      neg_in = 1'b1;
    end else begin
      a_in = 12'(QUAD_4 - n2);
      neg_in = 1'b0;
    end
  end

  // Products, each registered before the next use.
  assign sq      = 62'(m_r) * 62'(m_r);
  assign sq_hi   = sq[61:30];
  assign diff    = {1'b0, LOG2_10000_Q16} - {1'b0, e_r, frac_r};
  assign lq      = 21'((lq_prod_r + 51'(32'h2000_0000)) >> 30);
  assign res_bit = res_r + {1'b0, bit_r};
  assign xsq     = 62'(x_r) * 62'(x_r);
  assign yt      = 62'(y_r) * 62'(t_r);
  assign hprod   = 65'(q_r) * 65'(horner_recip(k_r));
  assign rc      = 50'(res_r[18:0]) * 50'(t_r);
  assign mag     = 17'((51'(rc) + 51'(34'h2_0000_0000)) >> 34);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (in_valid) state_nxt = F_LOG;
      F_LOG:  if (it_r == 4'd15) state_nxt = F_DIFF;
      F_DIFF: state_nxt = F_LQ;
      F_LQ:   state_nxt = F_SQI;
      F_SQI:  state_nxt = F_SQRT;
      F_SQRT: if (bit_r[0]) state_nxt = F_CX;
      F_CX:   state_nxt = F_CY;
      F_CY:   state_nxt = F_HMUL;
      F_HMUL: state_nxt = F_HDIV;
      F_HDIV: state_nxt = F_HSUB;
      F_HSUB: state_nxt = (k_r == 3'(HORNER_TERMS - 1)) ? F_MAG : F_HMUL;
      F_MAG:  state_nxt = F_PUSH;
      F_PUSH: if (!full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= F_IDLE;
    else        state_r <= state_nxt;
  end

  // Datapath registers of the sample.
  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          e_r    <= e_in;
          m_r    <= 31'(n1) << (5'd30 - 5'(e_in));
          frac_r <= '0;
          it_r   <= '0;
          a_r    <= a_in;
          neg_r  <= neg_in;
        end
      end
      F_LOG: begin
        it_r <= it_r + 4'd1;
        if (sq_hi[31]) begin
          m_r    <= sq_hi[31:1];
          frac_r <= {frac_r[14:0], 1'b1};
        end else begin
          m_r    <= sq_hi[30:0];
          frac_r <= {frac_r[14:0], 1'b0};
        end
      end
      F_DIFF: d_r <= diff[20] ? 20'd0 : diff[19:0];
      F_LQ:   lq_prod_r <= 51'(d_r) * 51'(TWO_LN2_Q30);
      F_SQI: begin
        v_r   <= {lq[20:0], 16'd0};
        res_r <= '0;
        bit_r <= 37'd1 << 36;
      end
      F_SQRT: begin
        if ({1'b0, v_r} >= res_bit) begin
          v_r   <= 37'({1'b0, v_r} - res_bit);
          res_r <= (res_r >> 1) + {1'b0, bit_r};
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      F_CX:   x_r <= 32'(a_r) * 32'(STEP_ANGLE_Q30);
      F_CY: begin
        y_r <= xsq[61:30];
        t_r <= Q30_ONE;
        k_r <= '0;
      end
      F_HMUL: q_r <= yt[61:30];
      // Division by the series constant as a reciprocal multiplication.
      F_HDIV: quot_r <= 32'(hprod >> horner_shift(k_r));
      F_HSUB: begin
        t_r <= (quot_r > 32'(Q30_ONE)) ? 31'd0 : 31'(32'(Q30_ONE) - quot_r);
        k_r <= k_r + 3'd1;
      end
      F_MAG: begin
        if (neg_r) z_r <= (mag > 17'd32768) ? -16'sd32768 : 16'(-mag);
        else       z_r <= (mag > 17'd32767) ? 16'sd32767 : 16'(mag);
      end
      default: ;
    endcase
  end

  assign in_ready  = (state_r == F_IDLE);
  assign push      = (state_r == F_PUSH) && !full;
  assign push_data = z_r;

endmodule

// ===== design/gsba_fifo.sv =====
// Two-entry queue of samples between the front and back ends.
module gsba_fifo import gsba_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic signed [15:0] wdata,
  output logic               full,
  input  logic               pop,
  output logic signed [15:0] rdata,
  output logic               valid
);

  logic signed [15:0] mem_r [2];
  logic               wp_r, rp_r;
  logic [1:0]         cnt_r;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  assign rdata = mem_r[rp_r];
  assign valid = (cnt_r != 2'd0);
  assign full  = (cnt_r == 2'd2);

endmodule

// ===== design/gsba_back.sv =====
// Back end: skipping, bin accumulation, bin average and the result register.
module gsba_back import gsba_pkg::*; #(
  parameter int MAX_BIN_SIZE = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_wr_t            cfg,
  input  logic               fifo_valid,
  input  logic signed [15:0] fifo_data,
  output logic               fifo_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_OUT  = 3'b100
  } bstate_t;

  bstate_t state_r;

  logic [7:0]       skip_count_r, skip_cnt_r;
  logic [10:0]      bin_size_r, mcnt_r, mcnt_inc, size_eff;
  logic [31:0]      sum_r, sum_new, sum_mag;
  logic [15:0]      bin_cnt_r;
  logic             neg_r;
  logic             div_start, div_done, close_bin;
  logic [DIV_W-1:0] div_q;
  out_item_t        out_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_count_r <= SKIP_COUNT_RESET;
      bin_size_r   <= BIN_SIZE_RESET;
    end else if (cfg.we) begin
      case (cfg.index)
        CFG_SKIP_COUNT: skip_count_r <= cfg.wdata[7:0];
        CFG_BIN_SIZE:   bin_size_r   <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // Effective bin size and the sum after this sample.
  always_comb begin
    size_eff = bin_size_r;
    if (size_eff == 11'd0) size_eff = 11'd1;
    if (32'(bin_size_r) > MAX_BIN_SIZE) size_eff = 11'(MAX_BIN_SIZE);
    sum_new  = sum_r + 32'(fifo_data);
    sum_mag  = sum_new[31] ? (32'd0 - sum_new) : sum_new;
    mcnt_inc = mcnt_r + 11'd1;
  end

  assign fifo_pop  = (state_r == B_IDLE) && fifo_valid;
  assign close_bin = fifo_pop && (skip_cnt_r == 8'd0) && (mcnt_inc >= size_eff);
  assign div_start = close_bin;

  gsba_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (size_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  // Counters, sum and the sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_IDLE;
      skip_cnt_r <= '0;
      mcnt_r     <= '0;
      sum_r      <= '0;
      bin_cnt_r  <= '0;
    end else begin
      case (state_r)
        B_IDLE: begin
          if (fifo_pop) begin
            if (skip_cnt_r != 8'd0) begin
              skip_cnt_r <= skip_cnt_r - 8'd1;
            end else begin
              skip_cnt_r <= skip_count_r;
              if (close_bin) begin
                sum_r   <= '0;
                mcnt_r  <= '0;
                neg_r   <= sum_new[31];
                state_r <= B_DIV;
              end else begin
                sum_r  <= sum_new;
                mcnt_r <= mcnt_inc;
              end
            end
          end
        end
        B_DIV: begin
          if (div_done) begin
            if (neg_r) begin
              out_r.bin_mean <= (div_q > 32'd32768) ? -16'sd32768 : 16'(32'd0 - div_q);
            end else begin
              out_r.bin_mean <= (div_q > 32'd32767) ? 16'sd32767 : 16'(div_q);
            end
            out_r.bin_number <= bin_cnt_r;
            bin_cnt_r        <= bin_cnt_r + 16'd1;
            state_r          <= B_OUT;
          end
        end
        B_OUT:   if (out_ready) state_r <= B_IDLE;
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid = (state_r == B_OUT);
  assign out_data  = out_r;

  // The divider only finishes while a bin average is awaited.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == B_DIV)
    else $error("divider finished outside the averaging step");

  // A waiting result leaves the bin cleared.
  a_cleared_when_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (sum_r == 32'd0) && (mcnt_r == 11'd0))
    else $error("bin not cleared while its result waits");

  // The delivered bin number is one behind the running counter.
  a_bin_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_r.bin_number == bin_cnt_r - 16'd1)
    else $error("bin number out of step with the bin counter");

  // No sample is taken while the result register is occupied.
  a_no_pop_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> !out_valid)
    else $error("sample taken while a result waits");

endmodule

// ===== design/gaussian_sample_bin_averager_core.sv =====
// Top level of the Gaussian sample bin averager: front end, queue and back end.
//
//   port group | direction | contents
//   in_        | input     | in_item_t: uniform_a, uniform_b; valid/ready
//   out_       | output    | out_item_t: bin_mean, bin_number; valid/ready
//   cfg_       | input     | write enable, index (0 skip_count, 1 bin_size), data
//
// The front end takes an item only after pushing the last sample: 16 log squaring
// steps, 19 square root steps, five cosine terms of multiply, divide and subtract,
// and eight single steps. The back end takes a sample per cycle; a closing sample
// holds it for the division, then the result waits for out_ready. A two-entry queue
// lets the front end keep working while a result waits, and the front stalls only
// when it is full. Reset is synchronous and active low; it needs no clearing pass.
module gaussian_sample_bin_averager_core import gsba_pkg::*; #(
  parameter int MAX_BIN_SIZE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_wdata
);

  logic               push, full, pop, qvalid;
  logic signed [15:0] push_data, qdata;
  cfg_wr_t            cfg;

  // Configuration write bundle.
  assign cfg = '{we: cfg_we, index: cfg_index, wdata: cfg_wdata};

  gsba_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  gsba_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_data),
    .full  (full),
    .pop   (pop),
    .rdata (qdata),
    .valid (qvalid)
  );

  gsba_back #(.MAX_BIN_SIZE(MAX_BIN_SIZE)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .fifo_valid (qvalid),
    .fifo_data  (qdata),
    .fifo_pop   (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
